// File: design/pcbe_pkg.sv
// Shared types, constants and helper functions of the piecewise cubic Bezier evaluator.
package pcbe_pkg;

   // Fixed-point format of the curve parameter and of the coordinates.
   localparam int FRAC_BITS  = 16;
   localparam int T_W        = 21;
   localparam int SEG_W      = T_W - FRAC_BITS;
   localparam int U_W        = FRAC_BITS + 1;
   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = DIFF_W + U_W + 1;
   localparam int SUM_W      = PROD_W + 1;

   // Control point storage: four banks, one for each point of a piece.
   localparam int MAX_PIECES = 16;
   localparam int PIECE_AW   = $clog2(MAX_PIECES);
   localparam int NUM_BANKS  = 4;
   localparam int INDEX_W    = 6;
   localparam int QUOT_W     = 5;
   localparam int PC_W       = 5;

   // Pipeline layout: memory read stage, then three interpolation levels.
   localparam int STAGE_L1   = 2;
   localparam int STAGE_L2   = 5;
   localparam int STAGE_L3   = 8;
   localparam int NUM_STAGES = 10;

   // Configuration port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-1:0] REG_PIECE_COUNT_ADDR = 3'd0;

   localparam logic [U_W-1:0]           U_ONE      = U_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

   // Reciprocal of three for a six-bit index: q = (v * 43) >> 7.
   localparam int DIV3_MUL   = 43;
   localparam int DIV3_SHIFT = 7;
   localparam int DIV3_W     = 12;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } opcode_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // Load enables of the three registers inside one interpolation unit.
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic load_c;
   } lerp_en_type;

   // Piece index of a shared control point index.
   function automatic logic [QUOT_W-1:0] div3(input logic [INDEX_W-1:0] v);
      logic [DIV3_W-1:0] prod;
      prod = DIV3_W'(v) * DIV3_W'(DIV3_MUL);
      return prod[DIV3_SHIFT +: QUOT_W];
   endfunction

endpackage

// File: design/piecewise_cubic_bezier_eval_unit.sv
// Top level of the piecewise cubic Bezier evaluator: point storage, control and pipeline.
//
// Usage: the req_ channel carries two kinds of beat. A write beat (opcode 0) stores
// one control point (x, y, z) at point_index; piece i of the chain uses points 3i to
// 3i+3, and indexes above 48 are dropped. An evaluate beat (opcode 1) carries curve_t,
// whose integer part picks the piece and whose 16-bit fraction is the position in it.
// Each evaluate beat gives one rsp_ beat with pos_x, pos_y, pos_z and out_of_range;
// a write beat gives none. Parameters at or past piece_count give the end point of the
// last piece, with out_of_range set only when strictly past it.
// piece_count is written through the csr_ port at address 0; the user must do so only
// while the unit is idle, as the unit itself does not enforce it. Throughput: one beat
// per clock while req_stall is low. Four point banks, one per control point of a piece,
// each deliver one point a cycle, and the interpolation pipeline takes a beat each
// cycle, unless rsp_stall holds it. Depth: ten register stages. A point written by one
// beat is seen by the very next beat.
// Reset empties the pipeline and sets piece_count to 1; points read before being written
// are undefined. When rsp_stall is high, the pipeline keeps accepting until every stage
// holds a result, then raises req_stall; nothing is dropped or repeated.
module piecewise_cubic_bezier_eval_unit
   import pcbe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [INDEX_W-1:0]  req_point_index,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_point_z,
   input  logic [T_W-1:0]      req_curve_t,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic signed [31:0]  rsp_pos_z,
   output logic                rsp_out_of_range,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   logic [PC_W-1:0]     piece_count_ff;
   logic [PC_W-1:0]     piece_count_in;
   logic                csr_write;

   logic                req_accept;
   logic                wr_accept;
   logic                eval_accept;

   logic [QUOT_W-1:0]   wr_quot;
   logic [QUOT_W-1:0]   wr_quot_m1;
   logic [INDEX_W-1:0]  wr_rem6;
   logic [1:0]          wr_rem;
   logic [NUM_BANKS-1:0] bank_wr_en;
   logic [PIECE_AW-1:0] bank_wr_addr [NUM_BANKS];
   point_type           wr_point;

   logic [PC_W-1:0]     pc_eff;
   logic [SEG_W-1:0]    seg;
   logic [FRAC_BITS-1:0] frac;
   logic [SEG_W-1:0]    seg_sel;
   logic [U_W-1:0]      eval_u;
   logic                eval_flag;
   logic [PIECE_AW-1:0] rd_addr;
   point_type           rd_point [NUM_BANKS];

   logic [NUM_STAGES:1] stage_ready;
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   logic [NUM_STAGES:1] flag_ff;
   logic [NUM_STAGES:1] flag_in;
   logic [U_W-1:0]      u_ff [1:STAGE_L3];
   logic [U_W-1:0]      u_in [1:STAGE_L3];

   coord_type           pts [NUM_BANKS][3];
   coord_type           lvl1 [3][3];
   coord_type           lvl2 [2][3];
   coord_type           lvl3 [3];
   lerp_en_type         en_l1;
   lerp_en_type         en_l2;
   lerp_en_type         en_l3;

   // Configuration register: piece_count at address 0.
   assign csr_pready     = 1'b1;
   assign csr_write      = csr_psel && csr_penable && csr_pwrite &&
                           (csr_paddr == REG_PIECE_COUNT_ADDR);
   assign piece_count_in = csr_pwdata[PC_W-1:0];
   assign csr_prdata     = (csr_paddr == REG_PIECE_COUNT_ADDR) ? CSR_DW'(piece_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_count_ff <= PC_W'(1);
      end else if (csr_write) begin
         piece_count_ff <= piece_count_in;
      end
   end

   // Backpressure: a stage takes a new beat when it is empty or its successor moves.
   always_comb begin
      stage_ready[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int i = NUM_STAGES - 1; i >= 1; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   assign req_stall   = !stage_ready[1];
   assign req_accept  = req_valid && !req_stall;
   assign wr_accept   = req_accept && (opcode_type'(req_opcode) == OP_WRITE);
   assign eval_accept = req_accept && (opcode_type'(req_opcode) == OP_EVAL);

   // Write decode: point 3q+r goes to bank r at row q; a joint point 3q also
   // goes to bank 3 at row q-1 as the end point of the previous piece.
   assign wr_quot    = div3(req_point_index);
   assign wr_quot_m1 = wr_quot - QUOT_W'(1);
   assign wr_rem6    = req_point_index - {wr_quot, 1'b0} - INDEX_W'(wr_quot);
   assign wr_rem     = wr_rem6[1:0];
   assign wr_point   = {req_point_x, req_point_y, req_point_z};

   always_comb begin
      for (int k = 0; k < NUM_BANKS - 1; k++) begin
         bank_wr_en[k]   = wr_accept && (wr_rem == 2'(k)) &&
                           (wr_quot < QUOT_W'(MAX_PIECES));
         bank_wr_addr[k] = wr_quot[PIECE_AW-1:0];
      end
      bank_wr_en[NUM_BANKS-1]   = wr_accept && (wr_rem == 2'd0) && (wr_quot != '0) &&
                                  (wr_quot <= QUOT_W'(MAX_PIECES));
      bank_wr_addr[NUM_BANKS-1] = wr_quot_m1[PIECE_AW-1:0];
   end

   // Parameter decode: clamp piece_count, pick the piece and the fraction.
   assign seg  = req_curve_t[T_W-1:FRAC_BITS];
   assign frac = req_curve_t[FRAC_BITS-1:0];

   always_comb begin
      if (piece_count_ff == '0) begin
         pc_eff = PC_W'(1);
      end else if (piece_count_ff > PC_W'(MAX_PIECES)) begin
         pc_eff = PC_W'(MAX_PIECES);
      end else begin
         pc_eff = piece_count_ff;
      end
      eval_flag = (seg > pc_eff) || ((seg == pc_eff) && (frac != '0));
      if (seg >= pc_eff) begin
         seg_sel = pc_eff - PC_W'(1);
         eval_u  = U_ONE;
      end else begin
         seg_sel = seg;
         eval_u  = {1'b0, frac};
      end
   end

   assign rd_addr = seg_sel[PIECE_AW-1:0];

   // Point banks; the read register forms stage 1 of the pipeline.
   for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
      pcbe_ram #(
         .WIDTH ($bits(point_type)),
         .DEPTH (MAX_PIECES)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_wr_en[k]),
         .wr_addr (bank_wr_addr[k]),
         .wr_data (wr_point),
         .rd_en   (stage_ready[1]),
         .rd_addr (rd_addr),
         .rd_data (rd_point[k])
      );
      assign pts[k][0] = rd_point[k].x;
      assign pts[k][1] = rd_point[k].y;
      assign pts[k][2] = rd_point[k].z;
   end

   // Sideband pipeline: valid, range flag and parameter travel with the data.
   always_comb begin
      valid_in[1] = eval_accept;
      flag_in[1]  = eval_flag;
      u_in[1]     = eval_u;
      for (int i = 2; i <= NUM_STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
         flag_in[i]  = flag_ff[i-1];
      end
      for (int i = 2; i <= STAGE_L3; i++) begin
         u_in[i] = u_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 1; i <= NUM_STAGES; i++) begin
            if (stage_ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= NUM_STAGES; i++) begin
         if (stage_ready[i]) begin
            flag_ff[i] <= flag_in[i];
         end
      end
      for (int i = 1; i <= STAGE_L3; i++) begin
         if (stage_ready[i]) begin
            u_ff[i] <= u_in[i];
         end
      end
   end

   // De Casteljau: three levels of interpolation, each three stages deep.
   assign en_l1 = '{load_a: stage_ready[STAGE_L1], load_b: stage_ready[STAGE_L1+1],
                    load_c: stage_ready[STAGE_L1+2]};
   assign en_l2 = '{load_a: stage_ready[STAGE_L2], load_b: stage_ready[STAGE_L2+1],
                    load_c: stage_ready[STAGE_L2+2]};
   assign en_l3 = '{load_a: stage_ready[STAGE_L3], load_b: stage_ready[STAGE_L3+1],
                    load_c: stage_ready[STAGE_L3+2]};

   for (genvar c = 0; c < 3; c++) begin : g_coord
      for (genvar j = 0; j < 3; j++) begin : g_lvl1
         pcbe_lerp u_lerp (
            .clock  (clock),
            .en     (en_l1),
            .a      (pts[j][c]),
            .b      (pts[j+1][c]),
            .mul_u  (u_ff[STAGE_L1]),
            .result (lvl1[j][c])
         );
      end
      for (genvar j = 0; j < 2; j++) begin : g_lvl2
         pcbe_lerp u_lerp (
            .clock  (clock),
            .en     (en_l2),
            .a      (lvl1[j][c]),
            .b      (lvl1[j+1][c]),
            .mul_u  (u_ff[STAGE_L2]),
            .result (lvl2[j][c])
         );
      end
      pcbe_lerp u_lerp_lvl3 (
         .clock  (clock),
         .en     (en_l3),
         .a      (lvl2[0][c]),
         .b      (lvl2[1][c]),
         .mul_u  (u_ff[STAGE_L3]),
         .result (lvl3[c])
      );
   end

   // The last interpolation register is the output register.
   assign rsp_valid        = valid_ff[NUM_STAGES];
   assign rsp_out_of_range = flag_ff[NUM_STAGES];
   assign rsp_pos_x        = lvl3[0];
   assign rsp_pos_y        = lvl3[1];
   assign rsp_pos_z        = lvl3[2];

endmodule

// File: design/pcbe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pcbe_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; the read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pcbe_lerp.sv
// Three-stage pipelined linear interpolation a + round((b - a) * u) in fixed point.
module pcbe_lerp
   import pcbe_pkg::*;
(
   input  logic           clock,
   input  lerp_en_type    en,
   input  coord_type      a,
   input  coord_type      b,
   input  logic [U_W-1:0] mul_u,
   output coord_type      result
);

   logic signed [DIFF_W-1:0] diff_in;
   logic signed [DIFF_W-1:0] diff_ff;
   coord_type                a_a_ff;
   coord_type                a_b_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum_in;
   coord_type                result_in;
   coord_type                result_ff;

   // Stage A: difference of the two end points.
   assign diff_in = DIFF_W'(b) - DIFF_W'(a);

   // Stage B: scale the difference by the parameter (mul_u is aligned with stage A).
   assign prod_in = diff_ff * $signed({1'b0, mul_u});

   // Stage C: add the start point and round to nearest, ties toward plus infinity.
   // The floor of the shifted sum keeps the result between a and b.
   assign sum_in    = (SUM_W'(a_b_ff) <<< FRAC_BITS) + SUM_W'(prod_ff) + ROUND_HALF;
   assign result_in = sum_in[FRAC_BITS +: COORD_W];

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         diff_ff <= diff_in;
         a_a_ff  <= a;
      end
      if (en.load_b) begin
         prod_ff <= prod_in;
         a_b_ff  <= a_a_ff;
      end
      if (en.load_c) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule
